FILE: rtl/core/ibscnt_pkg.sv
package ibscnt_pkg;

   localparam int CODE_ENTRIES = 256;
   localparam int RAW_BITS     = 8;
   localparam int CODE_BITS    = 2;
   localparam int CAT_BITS     = 2;
   localparam int IDX_BITS     = 6;
   localparam int RSP_BITS     = 32;
   localparam int TABLE_BITS   = 32;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef struct packed {
      logic active;
      logic code_we;
      logic cnt_we;
   } clr_ctl_type;

   // category of (mine, theirs) sits at bit 2*(4*mine+theirs)
   function automatic logic [CAT_BITS-1:0] pair_category(
      input logic [TABLE_BITS-1:0] tbl,
      input logic [CODE_BITS-1:0]  mine,
      input logic [CODE_BITS-1:0]  theirs
   );
      logic [4:0] sel;
      sel = {mine, theirs, 1'b0};
      return tbl[sel +: CAT_BITS];
   endfunction

endpackage

FILE: rtl/core/ibscnt_ram.sv
module ibscnt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/ibscnt_clear.sv
module ibscnt_clear import ibscnt_pkg::*; #(
   parameter int LEN       = 256,
   parameter int CNT_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   output clr_ctl_type            ctl,
   output logic [$clog2(LEN)-1:0] addr
);

   localparam int AW = $clog2(LEN);

   logic [AW-1:0] cnt_ff, cnt_in;
   logic          active_ff, active_in;

   always_comb begin
      active_in = active_ff && (cnt_ff != AW'(LEN - 1));
      cnt_in    = active_ff ? cnt_ff + AW'(1) : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign ctl.active  = active_ff;
   assign ctl.code_we = active_ff && (32'(cnt_ff) < 32'(CODE_ENTRIES));
   assign ctl.cnt_we  = active_ff && (32'(cnt_ff) < 32'(CNT_DEPTH));
   assign addr        = cnt_ff;

endmodule

FILE: rtl/core/pairwise_ibs_state_counter_top.sv
// Pairwise identity-by-state counter. After reset the block clears its code table
// and its counter memory, one entry a cycle, and holds busy high until the clearing is
// done. A transaction is taken when start is high and busy is low. A load writes the
// code table without raising busy. A read keeps busy high while in its read state and
// puts the count on rsp_count with rsp_valid for exactly one cycle, registered from
// that state; the receiver cannot stall, so the result must be captured in that cycle.
// A sample for individual i keeps busy high while the counter memory does one
// read-modify-write per earlier individual through a two-stage read pipeline. Counters
// saturate at 2^COUNT_BITS - 1 and read back clipped to 32 bits. The category table is
// written through csr_valid/csr_data, always ready; the user must write it only while
// the block is idle, since the block itself does not enforce this.
module pairwise_ibs_state_counter_top import ibscnt_pkg::*; #(
   parameter int INDIVIDUALS = 64,
   parameter int COUNT_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_opcode,
   input  logic [RAW_BITS-1:0]   req_raw_byte,
   input  logic [CODE_BITS-1:0]  req_code_value,
   input  logic [IDX_BITS-1:0]   req_row_index,
   input  logic [IDX_BITS-1:0]   req_col_index,
   input  logic [CAT_BITS-1:0]   req_category,
   output logic                  rsp_valid,
   output logic [RSP_BITS-1:0]   rsp_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TABLE_BITS-1:0] csr_data
);

   localparam int IDX_W     = $clog2(INDIVIDUALS);
   localparam int CNT_AW    = 2 * IDX_W + CAT_BITS;
   localparam int CNT_DEPTH = 1 << CNT_AW;
   localparam int CLR_LEN   = (CNT_DEPTH > CODE_ENTRIES) ? CNT_DEPTH : CODE_ENTRIES;
   localparam int CLR_AW    = $clog2(CLR_LEN);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CODE,
      ST_RUN,
      ST_READ
   } state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          row_ff, row_in;
   logic [CODE_BITS-1:0]      mine_ff, mine_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   logic                      p1_valid_ff, p1_valid_in;
   logic [IDX_W-1:0]          p1_col_ff, p1_col_in;
   logic                      p2_valid_ff, p2_valid_in;
   logic [CNT_AW-1:0]         p2_addr_ff, p2_addr_in;
   logic                      rd_ok_ff, rd_ok_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]       rsp_count_ff, rsp_count_in;
   logic [TABLE_BITS-1:0]     table_ff, table_in;

   clr_ctl_type               clr_ctl;
   logic [CLR_AW-1:0]         clr_addr;

   logic                      accept;
   logic [IDX_W+IDX_BITS-1:0] row_wide, col_wide;
   logic [IDX_W-1:0]          row_idx, col_idx;
   logic                      row_ok, pair_ok;
   logic                      issue;

   logic                      code_we;
   logic [RAW_BITS-1:0]       code_waddr;
   logic [CODE_BITS-1:0]      code_wdata, code_rdata;
   logic [CODE_BITS-1:0]      col_rdata;

   logic [CAT_BITS-1:0]       cat_b;
   logic [CNT_AW-1:0]         cnt_raddr_b, cnt_raddr, cnt_waddr;
   logic                      cnt_we;
   logic [COUNT_BITS-1:0]     cnt_rdata, cnt_wdata, cnt_inc;
   logic [COUNT_BITS+31:0]    cnt_wide;
   logic [COUNT_BITS-1:0]     cnt_hi;

   assign accept   = start && !busy;
   assign row_wide = {{IDX_W{1'b0}}, req_row_index};
   assign col_wide = {{IDX_W{1'b0}}, req_col_index};
   assign row_idx  = row_wide[IDX_W-1:0];
   assign col_idx  = col_wide[IDX_W-1:0];
   assign row_ok   = 32'(req_row_index) < 32'(INDIVIDUALS);
   assign pair_ok  = row_ok && (req_col_index < req_row_index);
   assign issue    = (state_ff == ST_RUN) && (k_ff != row_ff);

   ibscnt_clear #(
      .LEN       (CLR_LEN),
      .CNT_DEPTH (CNT_DEPTH)
   ) u_clear (
      .clock (clock),
      .reset (reset),
      .ctl   (clr_ctl),
      .addr  (clr_addr)
   );

   assign code_we    = clr_ctl.code_we || (accept && (req_opcode == OP_LOAD));
   assign code_waddr = clr_ctl.active ? clr_addr[RAW_BITS-1:0] : req_raw_byte;
   assign code_wdata = clr_ctl.active ? '0 : req_code_value;

   ibscnt_ram #(
      .WIDTH (CODE_BITS),
      .DEPTH (CODE_ENTRIES)
   ) u_code_ram (
      .clock (clock),
      .we    (code_we),
      .waddr (code_waddr),
      .wdata (code_wdata),
      .raddr (req_raw_byte),
      .rdata (code_rdata)
   );

   ibscnt_ram #(
      .WIDTH (CODE_BITS),
      .DEPTH (INDIVIDUALS)
   ) u_col_ram (
      .clock (clock),
      .we    (state_ff == ST_CODE),
      .waddr (row_ff),
      .wdata (code_rdata),
      .raddr (k_ff),
      .rdata (col_rdata)
   );

   assign cat_b       = pair_category(table_ff, mine_ff, col_rdata);
   assign cnt_raddr_b = {row_ff, p1_col_ff, cat_b};
   assign cnt_raddr   = (state_ff == ST_RUN) ? cnt_raddr_b : {row_idx, col_idx, req_category};
   assign cnt_inc     = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
   assign cnt_we      = clr_ctl.cnt_we || p2_valid_ff;
   assign cnt_waddr   = clr_ctl.active ? clr_addr[CNT_AW-1:0] : p2_addr_ff;
   assign cnt_wdata   = clr_ctl.active ? '0 : cnt_inc;

   ibscnt_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (CNT_DEPTH)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   // clip to the 32-bit result
   assign cnt_wide = {32'b0, cnt_rdata};
   assign cnt_hi   = cnt_wide[COUNT_BITS+31:32];

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      mine_in      = mine_ff;
      k_in         = k_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      p1_valid_in  = issue;
      p1_col_in    = k_ff;
      p2_valid_in  = p1_valid_ff;
      p2_addr_in   = cnt_raddr_b;
      table_in     = csr_valid ? csr_data : table_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!clr_ctl.active) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_SAMPLE: begin
                     if (row_ok) begin
                        row_in   = row_idx;
                        state_in = ST_CODE;
                     end
                  end
                  OP_READ: begin
                     rd_ok_in = pair_ok;
                     state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_CODE: begin
            mine_in  = code_rdata;
            k_in     = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (issue) begin
               k_in = k_ff + IDX_W'(1);
            end else if (!p1_valid_ff && !p2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            if (!rd_ok_ff) begin
               rsp_count_in = '0;
            end else if (|cnt_hi) begin
               rsp_count_in = '1;
            end else begin
               rsp_count_in = cnt_wide[31:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         table_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         table_ff     <= table_in;
      end
      row_ff       <= row_in;
      mine_ff      <= mine_in;
      k_ff         <= k_in;
      p1_col_ff    <= p1_col_in;
      p2_addr_ff   <= p2_addr_in;
      rd_ok_ff     <= rd_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;
   assign csr_ready = 1'b1;

endmodule

FILE: rtl/core/ibscnt_checker.sv
module ibscnt_checker import ibscnt_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_opcode,
   input logic       rsp_valid
);

   logic accept;
   assign accept = start && !busy;

   // a read transaction is answered by rsp_valid, through the read state and its registered strobe
   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == OP_READ) |=> ##1 rsp_valid)
      else $error("read transaction without response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode != OP_READ) |=> ##1 !rsp_valid)
      else $error("response without read transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_resp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response not preceded by busy cycle");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("not busy while clearing after reset");

endmodule

bind pairwise_ibs_state_counter_top ibscnt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid)
);

FILE: sim/pairwise_ibs_state_counter_top_test.sv
`timescale 1ns / 1ps

module pairwise_ibs_state_counter_top_test;
   import ibscnt_pkg::*;

   localparam int INDIVIDUALS      = 64;
   localparam int COUNT_BITS       = 32;
   localparam int SLOTS            = INDIVIDUALS * INDIVIDUALS * 4;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT   = 100000;
   localparam int RANDOM_PER_PHASE = 180;
   localparam int PHASES           = 6;

   typedef struct {
      logic [1:0]           opcode;
      logic [RAW_BITS-1:0]  raw_byte;
      logic [CODE_BITS-1:0] code_value;
      logic [IDX_BITS-1:0]  row_index;
      logic [IDX_BITS-1:0]  col_index;
      logic [CAT_BITS-1:0]  category;
      bit                   drain_first;
   } genotype_txn_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_opcode = '0;
   logic [RAW_BITS-1:0]   req_raw_byte = '0;
   logic [CODE_BITS-1:0]  req_code_value = '0;
   logic [IDX_BITS-1:0]   req_row_index = '0;
   logic [IDX_BITS-1:0]   req_col_index = '0;
   logic [CAT_BITS-1:0]   req_category = '0;
   logic                  rsp_valid;
   logic [RSP_BITS-1:0]   rsp_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TABLE_BITS-1:0] csr_data = '0;

   pairwise_ibs_state_counter_top #(
      .INDIVIDUALS(INDIVIDUALS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_raw_byte  (req_raw_byte),
      .req_code_value(req_code_value),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_category  (req_category),
      .rsp_valid     (rsp_valid),
      .rsp_count     (rsp_count),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   // predicted block state
   bit [CODE_BITS-1:0]  code_map [CODE_ENTRIES];
   bit [CODE_BITS-1:0]  marker_codes [INDIVIDUALS];
   bit [31:0]           tally [SLOTS];
   bit [TABLE_BITS-1:0] category_map;

   genotype_txn_type req_backlog [$];
   bit [31:0]        expected_counts [$];

   int idle_left, burst_left, quiet_cycles, filled, phase_items;
   int loads_done, samples_done, reads_done, ignored_done, reads_checked;
   int tables_written, mismatches;
   bit accepted;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   function automatic void apply_transaction(input genotype_txn_type t);
      bit [CODE_BITS-1:0] mine, theirs;
      bit [CAT_BITS-1:0]  cat;
      int                 slot;
      bit [31:0]          value;
      case (t.opcode)
         OP_LOAD: begin
            code_map[t.raw_byte] = t.code_value;
            loads_done++;
         end
         OP_SAMPLE: begin
            samples_done++;
            if (t.row_index < INDIVIDUALS) begin
               mine = code_map[t.raw_byte];
               marker_codes[t.row_index] = mine;
               for (int k = 0; k < t.row_index; k++) begin
                  theirs = marker_codes[k];
                  cat = category_map[2 * (4 * mine + theirs) +: 2];
                  slot = (t.row_index * INDIVIDUALS + k) * 4 + cat;
                  if (tally[slot] != 32'hFFFF_FFFF)
                     tally[slot]++;
               end
            end
         end
         OP_READ: begin
            value = '0;
            if (t.row_index < INDIVIDUALS && t.col_index < t.row_index)
               value = tally[(t.row_index * INDIVIDUALS + t.col_index) * 4 + t.category];
            expected_counts.push_back(value);
            reads_done++;
         end
         default: ignored_done++;
      endcase
   endfunction

   function automatic int next_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
         burst_left = $urandom_range(40, 20);
         return 0;
      end
      if (roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            apply_transaction(req_backlog.pop_front());
            idle_left = next_gap();
         end
         if (start && !accepted) begin
            // hold the transaction until busy drops
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (req_backlog.size() > 0 &&
                      !(req_backlog[0].drain_first && expected_counts.size() > 0)) begin
            req_opcode     <= req_backlog[0].opcode;
            req_raw_byte   <= req_backlog[0].raw_byte;
            req_code_value <= req_backlog[0].code_value;
            req_row_index  <= req_backlog[0].row_index;
            req_col_index  <= req_backlog[0].col_index;
            req_category   <= req_backlog[0].category;
            start          <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_counts.size() == 0) begin
            report_mismatch("count with no read outstanding", rsp_count, '0);
         end else begin
            reads_checked++;
            if (rsp_count !== expected_counts[0])
               report_mismatch("rsp_count", rsp_count, expected_counts[0]);
            void'(expected_counts.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_txn(input logic [1:0] op, input int unsigned raw, code, row, col,
                            cat);
      genotype_txn_type t;
      t.opcode      = op;
      t.raw_byte    = RAW_BITS'(raw);
      t.code_value  = CODE_BITS'(code);
      t.row_index   = IDX_BITS'(row);
      t.col_index   = IDX_BITS'(col);
      t.category    = CAT_BITS'(cat);
      t.drain_first = 1'b0;
      req_backlog.push_back(t);
      if (op != OP_UNUSED)
         phase_items++;
   endtask

   // half the traffic on a few hot bytes so loads and samples meet
   function automatic int unsigned pick_raw();
      return $urandom_range(1) ? $urandom_range(15) : $urandom_range(255);
   endfunction

   task automatic pair_read(input int m);
      int row;
      row = $urandom_range(m - 1, 1);
      queue_txn(OP_READ, $urandom, $urandom, row, $urandom_range(row - 1, 0), $urandom);
   endtask

   task automatic add_marker(input int n);
      for (int i = 0; i < n; i++) begin
         queue_txn(OP_SAMPLE, pick_raw(), $urandom, i, $urandom, $urandom);
         if (i > 0 && $urandom_range(9) == 0)
            pair_read(i + 1);
      end
      if (n > filled)
         filled = n;
      repeat ($urandom_range(4, 1)) pair_read(n);
   endtask

   task automatic directed_items();
      queue_txn(OP_READ, 8'h00, 0, 1, 0, 0);
      queue_txn(OP_LOAD, 8'hFF, 3, 63, 63, 3);
      queue_txn(OP_LOAD, 8'hAA, 2, 0, 0, 0);
      queue_txn(OP_LOAD, 8'h55, 1, 21, 42, 1);
      queue_txn(OP_LOAD, 8'h00, 0, 42, 21, 2);
      queue_txn(OP_UNUSED, 8'hFF, 3, 63, 63, 3);
      queue_txn(OP_SAMPLE, 8'hFF, 0, 0, 0, 0);
      queue_txn(OP_SAMPLE, 8'hAA, 0, 1, 0, 0);
      queue_txn(OP_SAMPLE, 8'h55, 3, 2, 63, 3);
      queue_txn(OP_READ, 8'hFF, 3, 1, 0, 3);
      queue_txn(OP_READ, 8'h00, 0, 2, 0, 3);
      queue_txn(OP_READ, 8'h00, 0, 2, 1, 2);
      // pairs that do not exist read as zero
      queue_txn(OP_READ, 8'h00, 0, 2, 2, 0);
      queue_txn(OP_READ, 8'h00, 0, 1, 63, 3);
      queue_txn(OP_READ, 8'h00, 0, 0, 0, 0);
      queue_txn(OP_READ, 8'h00, 0, 63, 0, 1);
      queue_txn(OP_READ, 8'hFF, 3, 63, 63, 3);
      // out of order: individual 1 sees the newer code of individual 0
      queue_txn(OP_SAMPLE, 8'h00, 0, 0, 0, 0);
      queue_txn(OP_SAMPLE, 8'h55, 0, 1, 0, 0);
      queue_txn(OP_READ, 8'h00, 0, 1, 0, 0);
      queue_txn(OP_READ, 8'h00, 0, 1, 0, 3);
      filled = 3;
   endtask

   task automatic random_items();
      int  full_at, roll, r, n;
      bit  full_done;
      full_at   = $urandom_range(RANDOM_PER_PHASE - 1);
      full_done = 1'b0;
      while (phase_items < RANDOM_PER_PHASE) begin
         if (!full_done && phase_items >= full_at) begin
            add_marker(INDIVIDUALS);
            full_done = 1'b1;
         end
         roll = $urandom_range(99);
         if (roll < 55) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(INDIVIDUALS - 1, 9)
                                          : $urandom_range(8, 2);
            add_marker(n);
         end else if (roll < 75) begin
            if ($urandom_range(1))
               pair_read(filled > 2 ? filled : 2);
            else
               queue_txn(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else if (roll < 88) begin
            queue_txn(OP_LOAD, pick_raw(), $urandom, $urandom, $urandom, $urandom);
         end else if (roll < 94) begin
            r = $urandom_range(filled < INDIVIDUALS - 1 ? filled : INDIVIDUALS - 1, 0);
            queue_txn(OP_SAMPLE, pick_raw(), $urandom, r, $urandom, $urandom);
            if (r == filled)
               filled++;
         end else begin
            queue_txn(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic settle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || start || expected_counts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_category_map(input bit [TABLE_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (csr_ready !== 1'b1);
      category_map = value;
      csr_valid <= 1'b0;
      tables_written++;
   endtask

   initial begin
      bit [TABLE_BITS-1:0] settings [PHASES];
      settings = '{32'hE4E4_E4E4, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFAA_5500,
                   $urandom, $urandom};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_category_map(settings[p]);
         phase_items = 0;
         if (p == 0)
            directed_items();
         else
            random_items();
         req_backlog[$urandom_range(req_backlog.size() - 1)].drain_first = 1'b1;
      end
      settle();
      $display("stimulus: %0d loads, %0d samples, %0d reads, %0d unused opcodes",
               loads_done, samples_done, reads_done, ignored_done);
      $display("%0d category tables, %0d counts checked, %0d mismatches",
               tables_written, reads_checked, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/ibscnt_pkg.sv
rtl/core/ibscnt_ram.sv
rtl/core/ibscnt_clear.sv
rtl/core/pairwise_ibs_state_counter_top.sv
rtl/core/ibscnt_checker.sv
sim/pairwise_ibs_state_counter_top_test.sv
